// ===== src/suks_pkg.sv =====
// ----------------------------------------------------------------------------
// suks_pkg
// Shared types and codes for the sorted unique key set.
// ----------------------------------------------------------------------------
package suks_pkg;

   localparam int OPCODE_WIDTH = 2;
   localparam int STATUS_WIDTH = 3;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 3'd0,
      ST_DUP       = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FIN,
      S_RESP,
      S_LIST_RD,
      S_LIST_DATA
   } state_type;

endpackage

// ===== src/sorted_unique_key_set.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_key_set
// Ordered set of unique keys held in one RAM, with insert, remove, lookup
// and list.
//
// Usage:
//   req_* carries one command word: opcode and key. rsp_* returns result
//   words: status, key, count after the operation, and tlast on the final
//   word of a command. Insert, remove and lookup give one word; list gives
//   one word per held key in ascending order (one status-empty word when the
//   set is empty).
//   Each command walks the stored keys once through the RAM read port,
//   inserting or closing the gap on the fly through the write port; insert,
//   remove and lookup then pass through a finish state to the result, and list
//   reads each key in a read state, as RAM read data is registered, and sends it from a data state.
//   One command is handled at a time; req_tready is high while idle, and the
//   block takes the next command while its last result still sits in the
//   output register.
//   A stalled receiver holds the output register and the list walk waits.
//   Reset empties the set (count zero); the RAM itself is not cleared, as
//   entries at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_unique_key_set #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // opcode, key
   input  logic [((suks_pkg::OPCODE_WIDTH + KEY_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // status, key_out, count
   output logic [((suks_pkg::STATUS_WIDTH + KEY_WIDTH + $clog2(CAPACITY + 1) + 7) / 8) * 8
                 - 1:0]                          rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int RSP_W   = ((suks_pkg::STATUS_WIDTH + KEY_WIDTH + CNT_W + 7) / 8) * 8;

   suks_pkg::state_type  state_ff, state_in;
   suks_pkg::op_type     op_ff, op_in;
   suks_pkg::status_type status_ff, status_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]     didx_ff, didx_in;
   logic                 dvld_ff, dvld_in;
   logic                 found_ff, found_in;
   logic                 ins_ff, ins_in;
   logic [KEY_WIDTH-1:0] carry_ff, carry_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   suks_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [KEY_WIDTH-1:0] rsp_key_ff, rsp_key_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [KEY_WIDTH-1:0] ram_wdata;
   logic                 ram_re;
   logic [IDX_W-1:0]     ram_raddr;
   logic [KEY_WIDTH-1:0] ram_rdata;

   logic                 out_free;
   logic                 full;
   logic [CNT_W-1:0]     didx_dec;
   logic [CNT_W-1:0]     cnt_dec;

   suks_ram #(
      .WIDTH(KEY_WIDTH),
      .DEPTH(CAPACITY)
   ) u_keys (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (cnt_ff == CNT_W'(CAPACITY));
   assign didx_dec   = didx_ff - CNT_W'(1);
   assign cnt_dec    = cnt_ff - CNT_W'(1);
   assign req_tready = (state_ff == suks_pkg::S_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_key_ff, rsp_status_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= suks_pkg::S_IDLE;
         cnt_ff       <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      key_ff        <= key_in;
      rd_idx_ff     <= rd_idx_in;
      didx_ff       <= didx_in;
      found_ff      <= found_in;
      ins_ff        <= ins_in;
      carry_ff      <= carry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      didx_in       = didx_ff;
      dvld_in       = 1'b0;
      found_in      = found_ff;
      ins_in        = ins_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = didx_ff[IDX_W-1:0];
      ram_wdata     = carry_ff;
      ram_re        = 1'b0;
      ram_raddr     = rd_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         suks_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in     = suks_pkg::op_type'(req_tdata[suks_pkg::OPCODE_WIDTH-1:0]);
               key_in    = req_tdata[suks_pkg::OPCODE_WIDTH +: KEY_WIDTH];
               rd_idx_in = '0;
               found_in  = 1'b0;
               ins_in    = 1'b0;
               if (op_in != suks_pkg::OP_LIST) begin
                  state_in = suks_pkg::S_SCAN;
               end else if (cnt_ff == '0) begin
                  status_in = suks_pkg::ST_EMPTY;
                  state_in  = suks_pkg::S_RESP;
               end else begin
                  state_in = suks_pkg::S_LIST_RD;
               end
            end
         end

         suks_pkg::S_SCAN: begin
            // issue the next read while the previous entry is processed
            if (rd_idx_ff < cnt_ff) begin
               ram_re    = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               dvld_in   = 1'b1;
               didx_in   = rd_idx_ff;
            end else if (!dvld_ff) begin
               state_in = suks_pkg::S_FIN;
            end
            if (dvld_ff) begin
               unique case (op_ff)
                  suks_pkg::OP_INSERT: begin
                     if (ins_ff) begin
                        // ripple the displaced key up one place
                        ram_we    = 1'b1;
                        ram_waddr = didx_ff[IDX_W-1:0];
                        ram_wdata = carry_ff;
                        carry_in  = ram_rdata;
                     end else if (!found_ff) begin
                        if (ram_rdata == key_ff) begin
                           found_in = 1'b1;
                        end else if (ram_rdata > key_ff && !full) begin
                           ram_we    = 1'b1;
                           ram_waddr = didx_ff[IDX_W-1:0];
                           ram_wdata = key_ff;
                           carry_in  = ram_rdata;
                           ins_in    = 1'b1;
                        end
                     end
                  end
                  suks_pkg::OP_REMOVE: begin
                     if (found_ff) begin
                        // close the gap: move each later key down one place
                        ram_we    = 1'b1;
                        ram_waddr = didx_dec[IDX_W-1:0];
                        ram_wdata = ram_rdata;
                     end else if (ram_rdata == key_ff) begin
                        found_in = 1'b1;
                     end
                  end
                  default: begin
                     if (ram_rdata == key_ff) begin
                        found_in = 1'b1;
                     end
                  end
               endcase
            end
         end

         suks_pkg::S_FIN: begin
            state_in = suks_pkg::S_RESP;
            unique case (op_ff)
               suks_pkg::OP_INSERT: begin
                  if (found_ff) begin
                     status_in = suks_pkg::ST_DUP;
                  end else if (full) begin
                     status_in = suks_pkg::ST_FULL;
                  end else begin
                     // append the key, or the last displaced one
                     ram_we    = 1'b1;
                     ram_waddr = cnt_ff[IDX_W-1:0];
                     ram_wdata = ins_ff ? carry_ff : key_ff;
                     cnt_in    = cnt_ff + CNT_W'(1);
                     status_in = suks_pkg::ST_OK;
                  end
               end
               suks_pkg::OP_REMOVE: begin
                  if (cnt_ff == '0) begin
                     status_in = suks_pkg::ST_EMPTY;
                  end else if (!found_ff) begin
                     status_in = suks_pkg::ST_NOT_FOUND;
                  end else begin
                     cnt_in    = cnt_dec;
                     status_in = suks_pkg::ST_OK;
                  end
               end
               default: begin
                  if (cnt_ff == '0) begin
                     status_in = suks_pkg::ST_EMPTY;
                  end else if (found_ff) begin
                     status_in = suks_pkg::ST_OK;
                  end else begin
                     status_in = suks_pkg::ST_NOT_FOUND;
                  end
               end
            endcase
         end

         suks_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_key_in    = key_ff;
               rsp_count_in  = cnt_ff;
               rsp_last_in   = 1'b1;
               state_in      = suks_pkg::S_IDLE;
            end
         end

         suks_pkg::S_LIST_RD: begin
            ram_re   = 1'b1;
            state_in = suks_pkg::S_LIST_DATA;
         end

         suks_pkg::S_LIST_DATA: begin
            // read data holds in the RAM output until the word is taken
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = suks_pkg::ST_OK;
               rsp_key_in    = ram_rdata;
               rsp_count_in  = cnt_ff;
               rsp_last_in   = (rd_idx_ff == cnt_dec);
               if (rd_idx_ff == cnt_dec) begin
                  state_in = suks_pkg::S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  state_in  = suks_pkg::S_LIST_RD;
               end
            end
         end

         default: begin
            state_in = suks_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/suks_ram.sv =====
// ----------------------------------------------------------------------------
// suks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module suks_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
